// File: hw/rtl/nth_root_waveshaper_top_macros.svh
// ---------------------------------------------------------------------------
// nth_root_waveshaper_top_macros.svh
// Assertion helpers for the waveshaper; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef NTH_ROOT_WAVESHAPER_TOP_MACROS_SVH
`define NTH_ROOT_WAVESHAPER_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define NRW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define NRW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NRW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define NRW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/nrw_pkg.sv
// ---------------------------------------------------------------------------
// nrw_pkg
// Shared constants, types and the exp2 root table for the waveshaper.
// ---------------------------------------------------------------------------
package nrw_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 24;
  localparam int LOG_FRAC_BITS_DEF = 16;

  // Q1.31 mantissa word
  localparam int MANT_W = 32;
  localparam int POS_W  = $clog2(MANT_W);
  localparam logic [MANT_W-1:0] MANT_ONE = {1'b1, {(MANT_W-1){1'b0}}};

  // register widths, gains in Q16
  localparam int PRE_W     = 22;
  localparam int POST_W    = 21;
  localparam int INV_W     = 17;
  localparam int GAIN_FRAC = 16;
  localparam int INV_FRAC  = 16;
  localparam logic [INV_W-1:0] INV_ROOT_RESET = {1'b1, {(INV_W-1){1'b0}}};

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PRE_W;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROOT  = 2'd2;

  typedef struct packed {
    logic neg;
    logic zero;
    logic block_end;
  } flags_t;

  typedef struct packed {
    flags_t            flg;
    logic              clip;   // exponent above the sample range
    logic              under;  // exponent below zero: result shifts out
    logic [POS_W-1:0]  sh;     // right shift of the mantissa
  } exp_side_t;

  // 2^(2^-k) in Q1.31, each entry the floor square root of the one before
  function automatic logic [MANT_W-1:0] exp2_root(input int k);
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    t = 64'd1 << 32;
    for (int i = 1; i <= k; i++) begin
      n   = t << 31;
      res = '0;
      bv  = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (n >= res + bv) begin
          n   = n - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      t = res;
    end
    return t[MANT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/nrw_in_if.sv
// ---------------------------------------------------------------------------
// nrw_in_if
// Sample input channel: valid/ready with one audio word.
// ---------------------------------------------------------------------------
interface nrw_in_if #(
  parameter int SAMPLE_WIDTH = nrw_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

// File: hw/rtl/nrw_out_if.sv
// ---------------------------------------------------------------------------
// nrw_out_if
// Shaped output channel: valid/ready with result word and flags.
// ---------------------------------------------------------------------------
interface nrw_out_if #(
  parameter int SAMPLE_WIDTH = nrw_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           block_end_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output block_end_out, output clipped,
                  input ready);
  modport sink   (input valid, input sample_out, input block_end_out, input clipped,
                  output ready);
endinterface

// File: hw/rtl/nrw_cfg_if.sv
// ---------------------------------------------------------------------------
// nrw_cfg_if
// Register write channel: valid/ready with index and data.
// ---------------------------------------------------------------------------
interface nrw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nrw_pkg::CFG_IDX_W-1:0]   index;
  logic [nrw_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/nrw_log2.sv
// ---------------------------------------------------------------------------
// nrw_log2
// Pipelined log2 of a magnitude: leading-one search, normalize, then one
// squaring stage per fraction bit.
// ---------------------------------------------------------------------------
module nrw_log2 #(
  parameter int SAMPLE_WIDTH  = nrw_pkg::SAMPLE_WIDTH_DEF,
  parameter int LOG_FRAC_BITS = nrw_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_WIDTH-1:0]        mag,
  input  nrw_pkg::flags_t                flg_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nrw_pkg::POS_W-1:0]      pos,
  output logic [LOG_FRAC_BITS-1:0]       frac,
  output nrw_pkg::flags_t                flg_out
);
  import nrw_pkg::*;

  localparam int F = LOG_FRAC_BITS;

  logic                    v_a, rdy_a;
  logic [SAMPLE_WIDTH-1:0] mag_a;
  flags_t                  flg_a;

  logic                    v_b, rdy_b;
  logic [SAMPLE_WIDTH-1:0] mag_b;
  logic [POS_W-1:0]        pos_b;
  logic [POS_W-1:0]        pos_enc;
  flags_t                  flg_b;

  logic              v_s     [0:F];
  logic              rdy_s   [0:F+1];
  logic [MANT_W-1:0] mant_s  [0:F];
  logic [F-1:0]      frac_s  [0:F];
  logic [POS_W-1:0]  pos_s   [0:F];
  flags_t            flg_s   [0:F];

  // stall chain: a stage loads when empty or when its successor moves
  assign rdy_s[F+1] = out_ready;
  assign rdy_b      = !v_b || rdy_s[0];
  assign rdy_a      = !v_a || rdy_b;
  assign in_ready   = rdy_a;

  // leading one
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < SAMPLE_WIDTH; i++) begin
      if (mag_a[i]) begin
        pos_enc = POS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else begin
      if (rdy_a) begin
        v_a <= in_valid;
      end
      if (rdy_b) begin
        v_b <= v_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      mag_a <= mag;
      flg_a <= flg_in;
    end
    if (rdy_b) begin
      mag_b <= mag_a;
      pos_b <= pos_enc;
      flg_b <= flg_a;
    end
  end

  // normalize to Q1.31
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (rdy_s[0]) begin
      v_s[0] <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[0]) begin
      mant_s[0] <= MANT_W'(mag_b) << (POS_W'(MANT_W-1) - pos_b);
      frac_s[0] <= '0;
      pos_s[0]  <= pos_b;
      flg_s[0]  <= flg_b;
    end
  end

  for (genvar k = 0; k <= F; k++) begin : g_rdy
    assign rdy_s[k] = !v_s[k] || rdy_s[k+1];
  end

  // one squaring per fraction bit, MSB first
  for (genvar k = 1; k <= F; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;

    assign sq = (2*MANT_W)'(mant_s[k-1]) * (2*MANT_W)'(mant_s[k-1]);
    assign t  = sq[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (rdy_s[k]) begin
        v_s[k] <= v_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_s[k]) begin
        mant_s[k] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        frac_s[k] <= {frac_s[k-1][F-2:0], t[MANT_W]};
        pos_s[k]  <= pos_s[k-1];
        flg_s[k]  <= flg_s[k-1];
      end
    end
  end

  assign out_valid = v_s[F];
  assign pos       = pos_s[F];
  assign frac      = frac_s[F];
  assign flg_out   = flg_s[F];

endmodule

// File: hw/rtl/nrw_exp2.sv
// ---------------------------------------------------------------------------
// nrw_exp2
// Pipelined 2^fraction in Q1.31: one table product per fraction bit.
// ---------------------------------------------------------------------------
module nrw_exp2 #(
  parameter int LOG_FRAC_BITS = nrw_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [LOG_FRAC_BITS-1:0]      fp,
  input  nrw_pkg::exp_side_t            side_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nrw_pkg::MANT_W-1:0]    mant,
  output nrw_pkg::exp_side_t            side_out
);
  import nrw_pkg::*;

  localparam int F = LOG_FRAC_BITS;
  localparam logic [MANT_W-1:0] ROOT_1 = exp2_root(1);

  logic              v_s   [1:F];
  logic              rdy_s [1:F+1];
  logic [MANT_W-1:0] m_s   [1:F];
  logic [F-1:0]      fp_s  [1:F];
  exp_side_t         sd_s  [1:F];

  assign rdy_s[F+1] = out_ready;
  assign in_ready   = rdy_s[1];

  for (genvar k = 1; k <= F; k++) begin : g_rdy
    assign rdy_s[k] = !v_s[k] || rdy_s[k+1];
  end

  // first bit: product with 1.0 is the table entry itself
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[1] <= 1'b0;
    end else if (rdy_s[1]) begin
      v_s[1] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s[1]) begin
      m_s[1]  <= fp[F-1] ? ROOT_1 : MANT_ONE;
      fp_s[1] <= fp;
      sd_s[1] <= side_in;
    end
  end

  for (genvar k = 2; k <= F; k++) begin : g_mul
    localparam logic [MANT_W-1:0] ROOT = exp2_root(k);
    logic [2*MANT_W-1:0] prod;

    assign prod = (2*MANT_W)'(m_s[k-1]) * (2*MANT_W)'(ROOT);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (rdy_s[k]) begin
        v_s[k] <= v_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_s[k]) begin
        m_s[k]  <= fp_s[k-1][F-k] ? prod[2*MANT_W-2:MANT_W-1] : m_s[k-1];
        fp_s[k] <= fp_s[k-1];
        sd_s[k] <= sd_s[k-1];
      end
    end
  end

  assign out_valid = v_s[F];
  assign mant      = m_s[F];
  assign side_out  = sd_s[F];

endmodule

// File: hw/rtl/nth_root_waveshaper_top.sv
// ---------------------------------------------------------------------------
// nth_root_waveshaper_top
// Power-law waveshaper: out = sign * FS * 2^((log2(|x|/FS) + pre)/n + post),
// with FS = 2^(SAMPLE_WIDTH-1), computed in the log2 domain with saturation.
// ---------------------------------------------------------------------------
//  channel   dir   handshake          word contents
//  samples   in    valid / ready      sample_in, block_end
//  shaped    out   valid / ready      sample_out, block_end_out, clipped
//  cfg       in    valid / ready=1    index, data (0 pre, 1 post, 2 1/n)
//
//  Throughput one word per cycle while shaped.ready is high. The log2
//  squaring chain and the exp2 product chain use one 32x32 multiplier per
//  stage and fraction bit, except the first exp2 bit, which takes the table entry.
//  rst (synchronous) empties all stages and loads the register defaults.
//  Each stage holds while full and its successor is stalled; empty stages
//  keep filling, so samples.ready drops only when every stage is full.
//  No memories, no clearing pass after reset.
// ---------------------------------------------------------------------------
`include "nth_root_waveshaper_top_macros.svh"

module nth_root_waveshaper_top #(
  parameter int SAMPLE_WIDTH  = nrw_pkg::SAMPLE_WIDTH_DEF,
  parameter int LOG_FRAC_BITS = nrw_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  nrw_in_if.sink     samples,
  nrw_out_if.source  shaped,
  nrw_cfg_if.sink    cfg
);
  import nrw_pkg::*;

  localparam int SW       = SAMPLE_WIDTH;
  localparam int F        = LOG_FRAC_BITS;
  localparam int GAIN_SHL = (F >= GAIN_FRAC) ? F - GAIN_FRAC : 0;
  localparam int GAIN_SHR = (F >= GAIN_FRAC) ? 0 : GAIN_FRAC - F;
  localparam int PREXW    = PRE_W + GAIN_SHL;
  localparam int POSTXW   = POST_W + GAIN_SHL;
  localparam int PD_W     = POS_W + 2;          // signed leading-one offset
  localparam int SUMW     = F + 8;              // log domain, pre-gained
  localparam int MULW     = SUMW + INV_W + 1;
  localparam int EW       = F + 11;             // exponent with bias
  localparam int IPW      = EW - F;

  localparam logic signed [EW-1:0]  E_BIAS  = EW'(64'(SW - 1) << F);
  localparam logic signed [IPW-1:0] IP_MAX  = IPW'(SW - 1);
  localparam logic [MANT_W-1:0]     LIM_POS = MANT_W'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [MANT_W-1:0]     LIM_NEG = MANT_W'(64'd1 << (SW - 1));
  localparam logic [SW-1:0]         S_MAX   = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0]         S_MIN   = {1'b1, {(SW-1){1'b0}}};

  // ---------------- configuration registers ----------------
  logic signed [PRE_W-1:0]  pre_gain;
  logic signed [POST_W-1:0] post_gain;
  logic [INV_W-1:0]         inv_root;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_gain  <= '0;
      post_gain <= '0;
      inv_root  <= INV_ROOT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PRE_GAIN:  pre_gain  <= cfg.data[PRE_W-1:0];
        REG_POST_GAIN: post_gain <= cfg.data[POST_W-1:0];
        REG_INV_ROOT:  inv_root  <= cfg.data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // gains rescaled from Q16 to QF (arithmetic right shift = floor)
  logic signed [PREXW-1:0]  pre_x;
  logic signed [POSTXW-1:0] post_x;
  logic signed [SUMW-1:0]   pre_qf;
  logic signed [EW-1:0]     post_qf;

  assign pre_x   = (PREXW'(pre_gain) <<< GAIN_SHL) >>> GAIN_SHR;
  assign post_x  = (POSTXW'(post_gain) <<< GAIN_SHL) >>> GAIN_SHR;
  assign pre_qf  = SUMW'(pre_x);
  assign post_qf = EW'(post_x);

  // ---------------- sign / magnitude split ----------------
  logic [SW-1:0] mag_in;
  flags_t        flg_in;

  assign flg_in.neg       = samples.sample_in[SW-1];
  assign flg_in.zero      = (samples.sample_in == '0);
  assign flg_in.block_end = samples.block_end;
  assign mag_in = flg_in.neg ? (~samples.sample_in + 1'b1) : samples.sample_in;

  // ---------------- log2 unit ----------------
  logic             log_valid;
  logic [POS_W-1:0] log_pos;
  logic [F-1:0]     log_frac;
  flags_t           log_flg;

  // stage ready signals
  logic rdy_l, rdy_m, rdy_y, rdy_r, rdy_o;

  nrw_log2 #(
    .SAMPLE_WIDTH  (SW),
    .LOG_FRAC_BITS (F)
  ) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .mag       (mag_in),
    .flg_in    (flg_in),
    .out_valid (log_valid),
    .out_ready (rdy_l),
    .pos       (log_pos),
    .frac      (log_frac),
    .flg_out   (log_flg)
  );

  // L = (p - (SW-1)) * 2^F + frac
  logic signed [PD_W-1:0] pdiff;
  logic signed [SUMW-1:0] l_val;

  assign pdiff = PD_W'(log_pos) - PD_W'(SW - 1);
  assign l_val = SUMW'($signed({pdiff, log_frac}));

  // ---------------- pre-gain, 1/n, post-gain stages ----------------
  logic                   v_l, v_m, v_y;
  logic signed [SUMW-1:0] sum_l;
  logic signed [MULW-1:0] prod_m;
  logic signed [EW-1:0]   e_y;
  flags_t                 flg_l, flg_m, flg_y;

  logic                   exp_ready;

  assign rdy_y = !v_y || exp_ready;
  assign rdy_m = !v_m || rdy_y;
  assign rdy_l = !v_l || rdy_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_l <= 1'b0;
      v_m <= 1'b0;
      v_y <= 1'b0;
    end else begin
      if (rdy_l) begin
        v_l <= log_valid;
      end
      if (rdy_m) begin
        v_m <= v_l;
      end
      if (rdy_y) begin
        v_y <= v_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_l) begin
      sum_l <= l_val + pre_qf;
      flg_l <= log_flg;
    end
    if (rdy_m) begin
      prod_m <= sum_l * $signed({1'b0, inv_root});
      flg_m  <= flg_l;
    end
    if (rdy_y) begin
      e_y   <= EW'(prod_m >>> INV_FRAC) + post_qf + E_BIAS;
      flg_y <= flg_m;
    end
  end

  // split exponent into integer and fraction
  logic signed [IPW-1:0] ip;
  exp_side_t             side_y;

  assign ip             = IPW'(e_y >>> F);
  assign side_y.flg     = flg_y;
  assign side_y.clip    = (ip > IP_MAX);
  assign side_y.under   = ip[IPW-1];
  assign side_y.sh      = ~ip[POS_W-1:0];   // 31 - ip for ip in 0..31

  // ---------------- exp2 unit ----------------
  logic              exp_valid;
  logic [MANT_W-1:0] exp_mant;
  exp_side_t         exp_side;

  nrw_exp2 #(
    .LOG_FRAC_BITS (F)
  ) u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_y),
    .in_ready  (exp_ready),
    .fp        (e_y[F-1:0]),
    .side_in   (side_y),
    .out_valid (exp_valid),
    .out_ready (rdy_r),
    .mant      (exp_mant),
    .side_out  (exp_side)
  );

  // ---------------- denormalize, saturate, sign ----------------
  logic              v_r, clip_r;
  logic [MANT_W-1:0] r_r;
  flags_t            flg_r;
  logic              v_o;

  assign rdy_o = !v_o || shaped.ready;
  assign rdy_r = !v_r || rdy_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= 1'b0;
    end else if (rdy_r) begin
      v_r <= exp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_r) begin
      r_r    <= exp_side.under ? '0 : (exp_mant >> exp_side.sh);
      clip_r <= exp_side.clip;
      flg_r  <= exp_side.flg;
    end
  end

  logic [MANT_W-1:0] limit, mag_f, signed_f;
  logic              over, clip_f;

  always_comb begin
    limit  = flg_r.neg ? LIM_NEG : LIM_POS;
    over   = (r_r > limit);
    clip_f = !flg_r.zero && (clip_r || over);
    priority if (flg_r.zero) begin
      mag_f = '0;
    end else if (clip_f) begin
      mag_f = limit;
    end else begin
      mag_f = r_r;
    end
    signed_f = flg_r.neg ? (MANT_W'(0) - mag_f) : mag_f;
  end

  // output register
  logic [SW-1:0] word_o;
  logic          bend_o, clip_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (rdy_o) begin
      v_o <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      word_o <= signed_f[SW-1:0];
      bend_o <= flg_r.block_end;
      clip_o <= clip_f;
    end
  end

  assign shaped.valid         = v_o;
  assign shaped.sample_out    = word_o;
  assign shaped.block_end_out = bend_o;
  assign shaped.clipped       = clip_o;

  // ---------------- assertions ----------------
  logic out_clip, at_limit, out_blocked;

  assign out_clip    = shaped.valid && shaped.clipped;
  assign at_limit    = (shaped.sample_out == S_MAX) || (shaped.sample_out == S_MIN);
  assign out_blocked = shaped.valid && !shaped.ready;

  // a clipped word sits at one of the two range extremes
  `NRW_ASSERT_IMP(a_clip_extreme, clk, rst, out_clip, at_limit, "clipped word off limit")
  // input stalls only when the whole pipe is full and the output is blocked
  `NRW_ASSERT_IMP(a_full_stall, clk, rst, !samples.ready, out_blocked, "early input stall")
  // a word waiting at the exponent stage is neither lost nor altered
  `NRW_ASSERT_NXT(a_hold_exp, clk, rst, v_y && !exp_ready, v_y && $stable(e_y), "exp hold")
  // a word waiting at the denormalize stage is neither lost nor altered
  `NRW_ASSERT_NXT(a_hold_den, clk, rst, v_r && !rdy_r, v_r && $stable(r_r), "denorm hold")

endmodule

// File: tb/nrw_shaper_checker.sv
// ---------------------------------------------------------------------------
// nrw_shaper_checker
// Watches the sample, shaped and register channels of the waveshaper. For
// every accepted sample it predicts the shaped word from its own copy of the
// gain registers and compares each shaped word with the oldest prediction.
// ---------------------------------------------------------------------------
module nrw_shaper_checker (
  input  logic clk,
  input  logic rst,
  nrw_in_if    samples,
  nrw_out_if   shaped,
  nrw_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);
  import nrw_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int FB = LOG_FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          block_end;
    logic          clipped;
  } shaped_word_t;

  logic signed [PRE_W-1:0]  pre_gain;
  logic signed [POST_W-1:0] post_gain;
  logic        [INV_W-1:0]  inv_root;

  longint unsigned root_tbl [1:FB];
  shaped_word_t    pending_shaped [$];

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.31
  initial begin : build_roots
    longint unsigned t;
    t = 64'd1 << 32;
    for (int k = 1; k <= FB; k++) begin
      t = floor_sqrt(t << 31);
      root_tbl[k] = t;
    end
  end

  function automatic longint to_log_q(longint v);
    if (FB >= GAIN_FRAC) return v <<< (FB - GAIN_FRAC);
    return v >>> (GAIN_FRAC - FB);
  endfunction

  function automatic longint unsigned exp2_mant(longint fp);
    longint unsigned m;
    m = 64'd1 << 31;
    for (int k = 1; k <= FB; k++) begin
      if ((fp >> (FB - k)) & 1) m = (m * root_tbl[k]) >> 31;
    end
    return m;
  endfunction

  function automatic shaped_word_t predict_shaped(logic signed [SW-1:0] x, logic be);
    shaped_word_t    w;
    longint          xs, lg, y, e, ip, fp, pre_l, post_l, inv_l;
    longint unsigned mag, lim, mant, frac, r, v;
    int              p;
    bit              neg, clip;
    xs     = x;
    neg    = xs < 0;
    mag    = neg ? -xs : xs;
    lim    = neg ? (64'd1 << (SW-1)) : ((64'd1 << (SW-1)) - 64'd1);
    pre_l  = pre_gain;
    post_l = post_gain;
    inv_l  = inv_root;
    r      = 0;
    clip   = 0;
    if (mag != 0) begin
      p = 0;
      while ((mag >> (p + 1)) != 0) p++;
      // log2 fraction by repeated squaring of the normalized mantissa
      mant = mag << (31 - p);
      frac = 0;
      for (int i = 0; i < FB; i++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant >= 64'h1_0000_0000) begin
          frac = frac | 64'd1;
          mant = mant >> 1;
        end
      end
      lg = (longint'(p) - (SW-1)) * ONE + longint'(frac);
      y  = (((lg + to_log_q(pre_l)) * inv_l) >>> INV_FRAC) + to_log_q(post_l);
      e  = y + (SW-1) * ONE;
      ip = e >>> FB;
      fp = e & (ONE - 1);
      if (ip > SW-1) begin
        clip = 1;
      end else begin
        r = (31 - ip >= 64) ? 64'd0 : (exp2_mant(fp) >> (31 - ip));
        if (r > lim) clip = 1;
      end
      if (clip) r = lim;
    end
    v           = neg ? (~r + 64'd1) : r;
    w.sample    = v[SW-1:0];
    w.block_end = be;
    w.clipped   = clip;
    return w;
  endfunction

  always @(posedge clk) begin : watch
    shaped_word_t got;
    shaped_word_t want;
    if (rst) begin
      pre_gain   = '0;
      post_gain  = '0;
      inv_root   = INV_ROOT_RESET;
      mismatches = 0;
      pending_shaped.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PRE_GAIN:  pre_gain  = cfg.data[PRE_W-1:0];
          REG_POST_GAIN: post_gain = cfg.data[POST_W-1:0];
          REG_INV_ROOT:  inv_root  = cfg.data[INV_W-1:0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready)
        pending_shaped.push_back(predict_shaped(samples.sample_in, samples.block_end));
      if (shaped.valid && shaped.ready) begin
        got = '{shaped.sample_out, shaped.block_end_out, shaped.clipped};
        if (pending_shaped.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("shaped word with none pending: sample %0d block_end %0b clipped %0b",
                     $signed(got.sample), got.block_end, got.clipped);
        end else begin
          want = pending_shaped.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: sample %0d/%0d block_end %0b/%0b clipped %0b/%0b (exp/got)",
                       $signed(want.sample), $signed(got.sample), want.block_end,
                       got.block_end, want.clipped, got.clipped);
          end
        end
      end
    end
    outstanding = pending_shaped.size();
  end

endmodule

// File: tb/nth_root_waveshaper_top_tb.sv
// ---------------------------------------------------------------------------
// nth_root_waveshaper_top_tb
// Drives samples and gain settings into the waveshaper, with a checker
// beside it: corner samples under corner gain settings first, then phases of
// random samples under random and extreme settings, with varied idling on
// both sides, one long output stall and one full drain mid-phase.
// ---------------------------------------------------------------------------
module nth_root_waveshaper_top_tb;
  import nrw_pkg::*;

  localparam int SW      = SAMPLE_WIDTH_DEF;
  localparam int LATENCY = 2 * LOG_FRAC_BITS_DEF + 8;
  localparam int LIMIT   = 400000;          // cycles
  localparam int PHASES  = 8;
  localparam int PHASE_WORDS = 78;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst;

  nrw_in_if  samples ();
  nrw_out_if shaped ();
  nrw_cfg_if cfg ();

  int mismatches;
  int outstanding;
  int idle_pct;     // sender idle chance per cycle
  int stall_pct;    // receiver stall chance per cycle
  int hold_req;     // long receiver hold-off, in cycles
  int cycles;

  logic [SW-1:0] corner_words [0:5];

  nth_root_waveshaper_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .shaped  (shaped),
    .cfg     (cfg)
  );

  nrw_shaper_checker chk (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .shaped      (shaped),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: any hang ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("nth_root_waveshaper_top_tb: errors");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    shaped.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        shaped.ready <= 1'b0;
      end else begin
        shaped.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One register write; the block takes it whenever ready is up.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // All three gains. Bits above a register's width are don't-care, so they
  // get random junk.
  task automatic set_gains(logic [PRE_W-1:0] pre, logic [POST_W-1:0] post,
                           logic [INV_W-1:0] inv);
    logic [CFG_DATA_W-1:0] d;
    write_reg(REG_PRE_GAIN, pre);
    d = CFG_DATA_W'($urandom);
    d[POST_W-1:0] = post;
    write_reg(REG_POST_GAIN, d);
    d = CFG_DATA_W'($urandom);
    d[INV_W-1:0] = inv;
    write_reg(REG_INV_ROOT, d);
  endtask

  // Offer one sample word; random idle cycles go in front of it.
  task automatic send_word(logic [SW-1:0] s, logic be);
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid     <= 1'b1;
    samples.sample_in <= s;
    samples.block_end <= be;
    do @(posedge clk); while (!samples.ready);
  endtask

  // Stop offering, wait for every pending shaped word, then let the
  // pipeline settle.
  task automatic drain();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [SW-1:0] random_sample();
    logic [SW-1:0] s;
    case ($urandom_range(3))
      0: s = SW'($urandom);
      1: s = SW'($urandom_range(300));                 // near zero
      2: s = {{(SW-1){1'b0}}, 1'b1} << $urandom_range(SW-1);  // powers of two
      default: s = {1'b0, {(SW-1){1'b1}}} - SW'($urandom_range(1000));  // near full scale
    endcase
    if ($urandom_range(1)) s = -s;
    return s;
  endfunction

  // Gains per random phase: extremes in 1, 2 and 5, any bits in 3, random otherwise.
  task automatic phase_gains(int ph);
    int pre, post, inv;
    pre  = int'($urandom_range(2097152)) - 1048576;
    post = int'($urandom_range(1048576)) - 524288;
    if ($urandom_range(1)) inv = 65536 / $urandom_range(20, 1);
    else inv = $urandom_range(65536, 3277);
    case (ph)
      1: set_gains(22'sd1048576, -21'sd524288, 17'd3277);
      2: set_gains(-22'sd1048576, 21'sd524288, 17'd65536);
      3: set_gains(PRE_W'($urandom), POST_W'($urandom), INV_W'($urandom));  // any bits
      5: set_gains({1'b1, {(PRE_W-1){1'b0}}}, {1'b0, {(POST_W-1){1'b1}}},
                   {INV_W{1'b1}});
      default: set_gains(PRE_W'(pre), POST_W'(post), INV_W'(inv));
    endcase
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    samples.valid     = 1'b0;
    samples.sample_in = '0;
    samples.block_end = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = REG_PRE_GAIN;
    cfg.data          = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    hold_req          = 0;

    corner_words[0] = '0;
    corner_words[1] = {{(SW-1){1'b0}}, 1'b1};
    corner_words[2] = {SW{1'b1}};                    // -1
    corner_words[3] = {1'b0, {(SW-1){1'b1}}};        // positive full scale
    corner_words[4] = {1'b1, {(SW-1){1'b0}}};        // negative full scale
    corner_words[5] = 24'h555555;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: corner samples under reset gains, then a gain that clips,
    // one that sends every result to zero, and a zero inverse root, which
    // maps every nonzero sample to a magnitude of 2^(SW-1+post).
    for (int c = 0; c < 4; c++) begin
      case (c)
        0: set_gains('0, '0, INV_ROOT_RESET);
        1: set_gains('0, 21'sd524288, 17'd65536);
        2: set_gains(-22'sd1048576, -21'sd524288, 17'd65536);
        default: begin
          set_gains(22'sd1048576, -21'sd65536, '0);
          write_reg(REG_UNUSED, CFG_DATA_W'($urandom));  // unused index, ignored
        end
      endcase
      for (int i = 0; i < 6; i++) send_word(corner_words[i], 1'((i + c) % 2));
      drain();
    end

    // Random phases. Idling pattern cycles through none, sender, receiver,
    // both.
    for (int ph = 0; ph < PHASES; ph++) begin
      phase_gains(ph);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      // long output hold-off while the sender keeps pushing: the pipeline
      // fills and samples.ready has to drop
      if (ph == 4) hold_req = 300;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // full stop mid-phase until everything has come out
        if (ph == 5 && i == PHASE_WORDS / 2) drain();
        send_word(random_sample(), $urandom_range(15) == 0);
      end
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("nth_root_waveshaper_top_tb: clean");
    end else begin
      $display("nth_root_waveshaper_top_tb: errors");
    end
    $finish;
  end

endmodule
